FILE: design/cdi_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and calendar tables for the date interval block.
// No dependencies; used by cdi_date_unit and calendar_date_interval.

package cdi_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned JDN_W   = 24;
    localparam int unsigned TOTAL_W = 22;
    localparam int unsigned WEEK_W  = 3;

    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 48;

    // floor(y / 100) as (y * DIV100_MUL) >> DIV100_SHIFT, exact for any 14-bit y
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;

    localparam int unsigned YEAR_MAX    = 9999;
    localparam int unsigned JDN_YEAR_OFS = 4716;
    localparam int unsigned JDN_BIAS    = 1524;
    localparam int unsigned MONTH_JAN   = 1;
    localparam int unsigned MONTH_FEB   = 2;
    localparam int unsigned MONTH_MAR   = 3;
    localparam int unsigned MONTH_DEC   = 12;
    localparam int unsigned FEB_LEAP    = 29;
    localparam int unsigned JAN_DAYS    = 31;

    // One date after validation and Julian day conversion
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               leap;
        logic               ok;
        logic [JDN_W-1:0]   jdn;
    } t_date_info;

    // Length of a month in a common year
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(30.6001 * (m + 1)) for the shifted month 3..14
    function automatic logic [8:0] f_month_ofs(input logic [MONTH_W:0] m);
        logic [8:0] ofs;
        case (m)
            5'd3:    ofs = 9'd122;
            5'd4:    ofs = 9'd153;
            5'd5:    ofs = 9'd183;
            5'd6:    ofs = 9'd214;
            5'd7:    ofs = 9'd244;
            5'd8:    ofs = 9'd275;
            5'd9:    ofs = 9'd306;
            5'd10:   ofs = 9'd336;
            5'd11:   ofs = 9'd367;
            5'd12:   ofs = 9'd397;
            5'd13:   ofs = 9'd428;
            5'd14:   ofs = 9'd459;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

FILE: design/cdi_date_unit.sv
`timescale 1ns / 1ps
// Two-stage date unit: validates one date and converts it to a Julian day number.
// Depends on cdi_pkg.

module cdi_date_unit (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [cdi_pkg::YEAR_W-1:0]   i_year,
    input  logic [cdi_pkg::MONTH_W-1:0]  i_month,
    input  logic [cdi_pkg::DAY_W-1:0]    i_day,
    output cdi_pkg::t_date_info          o_info
);

    // Stage 1: year shift for Jan/Feb, century quotients, year term of the day number
    logic                          w_early;
    logic [cdi_pkg::YEAR_W-1:0]    w_yadj;
    logic [cdi_pkg::MONTH_W:0]     w_madj;
    logic [26:0]                   w_craw_prod;
    logic [26:0]                   w_cadj_prod;
    logic [14:0]                   w_big_y;
    logic [22:0]                   w_x1;

    logic [cdi_pkg::YEAR_W-1:0]    r1_year;
    logic [cdi_pkg::MONTH_W-1:0]   r1_month;
    logic [cdi_pkg::DAY_W-1:0]     r1_day;
    logic [7:0]                    r1_craw;
    logic [7:0]                    r1_cadj;
    logic [22:0]                   r1_x1;
    logic [8:0]                    r1_x2;

    assign w_early     = (i_month <= 4'(cdi_pkg::MONTH_FEB));
    assign w_yadj      = w_early ? (i_year - 14'd1) : i_year;
    assign w_madj      = w_early ? ({1'b0, i_month} + 5'd12) : {1'b0, i_month};
    assign w_craw_prod = 27'(i_year) * 27'(cdi_pkg::DIV100_MUL);
    assign w_cadj_prod = 27'(w_yadj) * 27'(cdi_pkg::DIV100_MUL);
    assign w_big_y     = 15'(w_yadj) + 15'(cdi_pkg::JDN_YEAR_OFS);
    // floor(365.25 * Y) split into 365 * Y + Y / 4
    assign w_x1        = 23'(w_big_y) * 23'd365 + 23'(w_big_y >> 2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_year  <= i_year;
            r1_month <= i_month;
            r1_day   <= i_day;
            r1_craw  <= w_craw_prod[cdi_pkg::DIV100_SHIFT +: 8];
            r1_cadj  <= w_cadj_prod[cdi_pkg::DIV100_SHIFT +: 8];
            r1_x1    <= w_x1;
            r1_x2    <= cdi_pkg::f_month_ofs(w_madj);
        end
    end

    // Stage 2: leap rule, range check, day number sum
    logic                          w_century;
    logic                          w_leap;
    logic [cdi_pkg::DAY_W-1:0]     w_mdays;
    logic                          w_ok;
    logic [cdi_pkg::JDN_W-1:0]     w_jdn;
    cdi_pkg::t_date_info           r2_info;

    assign w_century = (15'(r1_year) == 15'(r1_craw) * 15'd100);
    assign w_leap    = w_century ? (r1_craw[1:0] == 2'd0) : (r1_year[1:0] == 2'd0);
    assign w_mdays   = (r1_month == 4'(cdi_pkg::MONTH_FEB) && w_leap)
                     ? 5'(cdi_pkg::FEB_LEAP) : cdi_pkg::f_month_len(r1_month);
    assign w_ok      = (r1_year >= 14'd1) && (r1_year <= 14'(cdi_pkg::YEAR_MAX))
                    && (r1_month >= 4'(cdi_pkg::MONTH_JAN))
                    && (r1_month <= 4'(cdi_pkg::MONTH_DEC))
                    && (r1_day >= 5'd1) && (r1_day <= w_mdays);
    assign w_jdn     = 24'(r1_x1) + 24'(r1_x2) + 24'(r1_day) + 24'd2
                     - 24'(r1_cadj) + 24'(r1_cadj >> 2) - 24'(cdi_pkg::JDN_BIAS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_info.year  <= r1_year;
            r2_info.month <= r1_month;
            r2_info.day   <= r1_day;
            r2_info.leap  <= w_leap;
            r2_info.ok    <= w_ok;
            r2_info.jdn   <= w_jdn;
        end
    end

    assign o_info = r2_info;

endmodule

FILE: design/calendar_date_interval.sv
`timescale 1ns / 1ps
// Top level of the calendar date interval block: four-stage pipeline.
// Depends on cdi_pkg and cdi_date_unit.

// Takes one pair of Gregorian dates per transaction and returns the interval from the
// earlier to the later one as years, months, weeks and leftover days, together with the
// absolute difference of their Julian day numbers. A date with a year outside 1..9999,
// a month outside 1..12, a zero day or a day past its month's length (29 February only
// in leap years) sets the tuser flag and zeroes every other field. When the day count
// goes negative a month is borrowed with the length of the month before the later
// date's month; should it still be negative, a January is borrowed as well. The block
// accepts one transaction every cycle while the output is not stalled, and each result
// passes through four register stages (two in each date unit for validation and day
// number, one for ordering and raw differences, one for the borrow and week split). All
// stages advance together whenever the output register is empty or being taken, so
// downstream back-pressure stalls the whole pipeline without loss. No configuration;
// reset clears only the stage valid bits.

module calendar_date_interval (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // first_year[13:0], first_month[17:14], first_day[22:18],
    // second_year[36:23], second_month[40:37], second_day[45:41], zero [47:46]
    input  logic [cdi_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // diff_years[13:0], diff_months[17:14], diff_weeks[20:18], diff_days[23:21],
    // day_span[45:24], zero [47:46]
    output logic [cdi_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // bad_date[0]
    output logic [0:0]                        m_axis_tuser
);

    // Whole pipeline moves when the output register can take a new transaction
    logic w_adv;
    logic r_v1, r_v2, r_v3, r_v4;

    assign w_adv         = !r_v4 || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stages 1 and 2: one date unit per date
    cdi_pkg::t_date_info w_a;
    cdi_pkg::t_date_info w_b;

    cdi_date_unit u_date_a (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_year  (s_axis_tdata[13:0]),
        .i_month (s_axis_tdata[17:14]),
        .i_day   (s_axis_tdata[22:18]),
        .o_info  (w_a)
    );

    cdi_date_unit u_date_b (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_year  (s_axis_tdata[36:23]),
        .i_month (s_axis_tdata[40:37]),
        .i_day   (s_axis_tdata[45:41]),
        .o_info  (w_b)
    );

    // Stage 3: order the dates, take raw differences. The day number is monotone in
    // the date, so the later date also has the larger day number.
    logic                 w_swap;
    cdi_pkg::t_date_info  w_early;
    cdi_pkg::t_date_info  w_late;

    logic [13:0]                  r3_dy;
    logic signed [4:0]            r3_dm;
    logic signed [6:0]            r3_dd;
    logic [3:0]                   r3_mb;
    logic                         r3_leapb;
    logic [cdi_pkg::TOTAL_W-1:0]  r3_total;
    logic                         r3_bad;

    assign w_swap  = (w_a.year != w_b.year)   ? (w_a.year > w_b.year)
                   : (w_a.month != w_b.month) ? (w_a.month > w_b.month)
                   : (w_a.day > w_b.day);
    assign w_early = w_swap ? w_b : w_a;
    assign w_late  = w_swap ? w_a : w_b;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_dy    <= w_late.year - w_early.year;
            r3_dm    <= $signed({1'b0, w_late.month}) - $signed({1'b0, w_early.month});
            r3_dd    <= $signed({2'b0, w_late.day}) - $signed({2'b0, w_early.day});
            r3_mb    <= w_late.month;
            r3_leapb <= w_late.leap;
            r3_total <= cdi_pkg::TOTAL_W'(w_late.jdn - w_early.jdn);
            r3_bad   <= !(w_a.ok && w_b.ok);
        end
    end

    // Stage 4: borrow months, fold negative months into years, split days into weeks
    logic [4:0]           w_blen;
    logic signed [6:0]    w_dd1, w_dd2;
    logic signed [4:0]    w_dm1, w_dm2, w_dm3;
    logic signed [14:0]   w_dy3;
    logic                 w_zero;
    logic [4:0]           w_dd5;
    logic [10:0]          w_wprod;
    logic [2:0]           w_weeks;
    logic [2:0]           w_days;

    logic [13:0]                  r_years;
    logic [3:0]                   r_months;
    logic [2:0]                   r_weeks;
    logic [2:0]                   r_days;
    logic [cdi_pkg::TOTAL_W-1:0]  r_total;
    logic                         r_bad;

    always_comb begin
        if (r3_mb == 4'(cdi_pkg::MONTH_JAN)) begin
            w_blen = 5'(cdi_pkg::JAN_DAYS);
        end else if (r3_mb == 4'(cdi_pkg::MONTH_MAR) && r3_leapb) begin
            w_blen = 5'(cdi_pkg::FEB_LEAP);
        end else begin
            w_blen = cdi_pkg::f_month_len(r3_mb - 4'd1);
        end

        w_dd1 = r3_dd;
        w_dm1 = r3_dm;
        if (r3_dd < 0) begin
            w_dd1 = r3_dd + $signed({2'b0, w_blen});
            w_dm1 = r3_dm - 5'sd1;
        end

        w_dd2 = w_dd1;
        w_dm2 = w_dm1;
        if (w_dd1 < 0) begin
            w_dd2 = w_dd1 + 7'sd31;
            w_dm2 = w_dm1 - 5'sd1;
        end

        w_dm3 = w_dm2;
        w_dy3 = $signed({1'b0, r3_dy});
        if (w_dm2 < 0) begin
            w_dm3 = w_dm2 + 5'sd12;
            w_dy3 = $signed({1'b0, r3_dy}) - 15'sd1;
        end

        w_zero  = r3_bad || (w_dy3 < 0) || (w_dd2 < 0);
        // dd / 7 as (dd * 37) >> 8, exact for dd up to 34
        w_dd5   = w_dd2[4:0];
        w_wprod = 11'(w_dd5) * 11'd37;
        w_weeks = w_wprod[10:8];
        w_days  = 3'(w_dd5 - 5'(w_weeks) * 5'd7);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_years  <= w_zero ? 14'd0 : w_dy3[13:0];
            r_months <= w_zero ? 4'd0 : w_dm3[3:0];
            r_weeks  <= w_zero ? 3'd0 : w_weeks;
            r_days   <= w_zero ? 3'd0 : w_days;
            r_total  <= r3_bad ? '0 : r3_total;
            r_bad    <= r3_bad;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {2'b00, r_total, r_days, r_weeks, r_months, r_years};
    assign m_axis_tuser  = r_bad;

    // A flagged date carries an all-zero interval
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("bad date result carries non-zero fields");

    // Remainder fields stay inside their calendar ranges
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_months <= 4'd11 && r_weeks <= 3'd4 && r_days <= 3'd6))
        else $error("interval remainder out of range");

    // An accepted transaction occupies the first stage next cycle
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v1)
        else $error("accepted transaction lost at pipeline entry");

    // A stall freezes the stage valid bits
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_v1) && $stable(r_v2) && $stable(r_v3) && r_v4))
        else $error("pipeline moved during a stall");

endmodule
